// ===== rtl/pctc_pkg.sv =====
// shared types and constants for the prefix code table codec
package pctc_pkg;
    localparam int REQ_W  = 3;
    localparam int SYM_W  = 8;
    localparam int LEN_W  = 6;
    localparam int CODE_W = 32;
    localparam int KIND_W = 2;

    localparam logic [REQ_W-1:0] REQ_LOAD    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ENCODE  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_FLUSH   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DECODE  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_RESTART = 3'd4;

    localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SYM   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] out_kind;
        logic [SYM_W-1:0]  out_value;
        logic              last;
    } t_res;
endpackage

// ===== rtl/pctc_in_if.sv =====
// request channel interface
interface pctc_in_if;
    import pctc_pkg::*;
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [SYM_W-1:0]  symbol;
    logic [LEN_W-1:0]  code_length;
    logic [CODE_W-1:0] code_bits;
    logic [SYM_W-1:0]  data_byte;
    modport source (output valid, req_type, symbol, code_length, code_bits, data_byte,
                    input ready);
    modport sink (input valid, req_type, symbol, code_length, code_bits, data_byte,
                  output ready);
endinterface

// ===== rtl/pctc_out_if.sv =====
// result channel interface
interface pctc_out_if;
    import pctc_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] out_kind;
    logic [SYM_W-1:0]  out_value;
    logic              last;
    modport source (output valid, out_kind, out_value, last, input ready);
    modport sink (input valid, out_kind, out_value, last, output ready);
endinterface

// ===== rtl/pctc_core.sv =====
// table memory, bit-serial encoder and decoder sequencer
module pctc_core #(
    parameter int TABLE_DEPTH  = 256,
    parameter int MAX_CODE_LEN = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    pctc_in_if.sink        i_req,
    output logic           o_push_valid,
    output pctc_pkg::t_res o_push,
    input  logic           i_push_ready
);
    import pctc_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_ENC_RD, S_ENC_CMP, S_BITS, S_DEC_SHIFT, S_DEC_RD, S_DEC_CMP, S_FINISH
    } t_state;

    logic [SYM_W-1:0]  mem_sym  [TABLE_DEPTH];
    logic [LEN_W-1:0]  mem_len  [TABLE_DEPTH];
    logic [CODE_W-1:0] mem_code [TABLE_DEPTH];

    t_state            r_state;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_idx;
    logic [SYM_W-1:0]  r_rd_sym;
    logic [LEN_W-1:0]  r_rd_len;
    logic [CODE_W-1:0] r_rd_code;
    logic [SYM_W-1:0]  r_sym;
    logic [CODE_W-1:0] r_code;
    logic [LEN_W-1:0]  r_cnt;
    logic [SYM_W-1:0]  r_pack;
    logic [3:0]        r_fill;
    logic [CODE_W-1:0] r_mcode;
    logic [LEN_W-1:0]  r_mlen;
    logic [SYM_W-1:0]  r_data;
    logic [3:0]        r_bits_left;
    logic              r_hold_v;
    logic [KIND_W-1:0] r_hold_kind;
    logic [SYM_W-1:0]  r_hold_val;

    logic              accept;
    logic              load_we;
    logic [CODE_W-1:0] load_mask;
    logic [LEN_W-1:0]  cnt_m1;
    logic              cur_bit;
    logic              in_range;
    logic              dec_hit;
    logic              gen;
    logic [KIND_W-1:0] gen_kind;
    logic [SYM_W-1:0]  gen_val;
    logic              stall;
    logic              rd_en;

    assign accept   = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign load_we  = accept && (i_req.req_type == REQ_LOAD)
                      && (r_count < CW'(TABLE_DEPTH))
                      && (i_req.code_length <= LEN_W'(MAX_CODE_LEN));
    assign cnt_m1   = r_cnt - LEN_W'(1);
    assign cur_bit  = r_code[cnt_m1[4:0]];
    assign in_range = (r_idx < r_count);
    assign dec_hit  = (r_rd_len == r_mlen) && (r_rd_code == r_mcode);
    assign rd_en    = ((r_state == S_ENC_RD) || (r_state == S_DEC_RD)) && in_range;

    always_comb begin
        for (int k = 0; k < CODE_W; k++) begin
            load_mask[k] = (LEN_W'(k) < i_req.code_length);
        end
    end

    always_comb begin
        gen      = 1'b0;
        gen_kind = KIND_BYTE;
        gen_val  = '0;
        case (r_state)
            S_BITS: begin
                if (r_cnt != '0 && r_fill == 4'd7) begin
                    gen     = 1'b1;
                    gen_val = {r_pack[SYM_W-2:0], cur_bit};
                end
            end
            S_DEC_RD: begin
                if (!in_range && r_mlen >= LEN_W'(MAX_CODE_LEN)) begin
                    gen      = 1'b1;
                    gen_kind = KIND_ERROR;
                end
            end
            S_DEC_CMP: begin
                if (dec_hit) begin
                    gen      = 1'b1;
                    gen_kind = KIND_SYM;
                    gen_val  = r_rd_sym;
                end
            end
            default: ;
        endcase
    end

    assign stall        = gen && r_hold_v && !i_push_ready;
    assign o_push_valid = r_hold_v && (gen || (r_state == S_FINISH));
    assign o_push       = '{out_kind: r_hold_kind, out_value: r_hold_val,
                            last: (r_state == S_FINISH)};

    always_ff @(posedge i_clk) begin
        if (load_we) begin
            mem_sym[r_count[AW-1:0]]  <= i_req.symbol;
            mem_len[r_count[AW-1:0]]  <= i_req.code_length;
            mem_code[r_count[AW-1:0]] <= i_req.code_bits & load_mask;
        end
        if (rd_en) begin
            r_rd_sym  <= mem_sym[r_idx[AW-1:0]];
            r_rd_len  <= mem_len[r_idx[AW-1:0]];
            r_rd_code <= mem_code[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_pack   <= '0;
            r_fill   <= '0;
            r_mcode  <= '0;
            r_mlen   <= '0;
            r_hold_v <= 1'b0;
        end else if (!stall) begin
            if (gen) begin
                r_hold_v    <= 1'b1;
                r_hold_kind <= gen_kind;
                r_hold_val  <= gen_val;
            end
            case (r_state)
                S_IDLE: begin
                    if (load_we) begin
                        r_count <= r_count + CW'(1);
                    end
                    if (accept) begin
                        r_idx <= '0;
                        r_sym <= i_req.symbol;
                        case (i_req.req_type)
                            REQ_ENCODE: r_state <= S_ENC_RD;
                            REQ_FLUSH: begin
                                r_code  <= '1;
                                r_cnt   <= (r_fill == 4'd0) ? LEN_W'(0)
                                                            : LEN_W'(4'd8 - r_fill);
                                r_state <= S_BITS;
                            end
                            REQ_DECODE: begin
                                r_data      <= i_req.data_byte;
                                r_bits_left <= 4'd8;
                                r_state     <= S_DEC_SHIFT;
                            end
                            REQ_RESTART: begin
                                r_mcode <= '0;
                                r_mlen  <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_ENC_RD: begin
                    r_state <= in_range ? S_ENC_CMP : S_FINISH;
                end
                S_ENC_CMP: begin
                    if (r_rd_sym == r_sym) begin
                        r_code  <= r_rd_code;
                        r_cnt   <= r_rd_len;
                        r_state <= S_BITS;
                    end else begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= S_ENC_RD;
                    end
                end
                S_BITS: begin
                    if (r_cnt == '0) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_cnt <= cnt_m1;
                        if (r_fill == 4'd7) begin
                            r_pack <= '0;
                            r_fill <= '0;
                        end else begin
                            r_pack <= {r_pack[SYM_W-2:0], cur_bit};
                            r_fill <= r_fill + 4'd1;
                        end
                    end
                end
                S_DEC_SHIFT: begin
                    if (r_bits_left == 4'd0) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_mcode     <= {r_mcode[CODE_W-2:0], r_data[SYM_W-1]};
                        r_mlen      <= r_mlen + LEN_W'(1);
                        r_data      <= {r_data[SYM_W-2:0], 1'b0};
                        r_bits_left <= r_bits_left - 4'd1;
                        r_idx       <= '0;
                        r_state     <= S_DEC_RD;
                    end
                end
                S_DEC_RD: begin
                    if (in_range) begin
                        r_state <= S_DEC_CMP;
                    end else begin
                        if (gen) begin
                            r_mcode <= '0;
                            r_mlen  <= '0;
                        end
                        r_state <= S_DEC_SHIFT;
                    end
                end
                S_DEC_CMP: begin
                    if (dec_hit) begin
                        r_mcode <= '0;
                        r_mlen  <= '0;
                        r_state <= S_DEC_SHIFT;
                    end else begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= S_DEC_RD;
                    end
                end
                S_FINISH: begin
                    if (!r_hold_v || i_push_ready) begin
                        r_hold_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/pctc_out_reg.sv =====
// output register stage for result beats
module pctc_out_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  pctc_pkg::t_res i_res,
    output logic           o_ready,
    pctc_out_if.source     o_res
);
    import pctc_pkg::*;

    logic r_valid;
    t_res r_res;

    assign o_ready         = !r_valid || o_res.ready;
    assign o_res.valid     = r_valid;
    assign o_res.out_kind  = r_res.out_kind;
    assign o_res.out_value = r_res.out_value;
    assign o_res.last      = r_res.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_res <= i_res;
            end
        end
    end
endmodule

// ===== rtl/prefix_code_table_codec.sv =====
// prefix code table codec: one item in work at a time, input ready only while idle
// every item is accepted while idle; load, restart and unused types end there
// encode: scan entries for the symbol, then shift out its code bits (none if not found)
// flush: pad with 1 bits to a byte edge; decode: match the code after each new bit;
// all end in finish; a result beat waits for the next one or the end, a held-off sink stalls
// synchronous active-low reset clears the table count, pack and match state; table undefined
module prefix_code_table_codec #(
    parameter int TABLE_DEPTH  = 256,
    parameter int MAX_CODE_LEN = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pctc_in_if.sink     i_req,
    pctc_out_if.source  o_res
);
    import pctc_pkg::*;

    logic push_valid;
    logic push_ready;
    t_res push;

    pctc_core #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .o_push_valid (push_valid),
        .o_push       (push),
        .i_push_ready (push_ready)
    );

    pctc_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (push_valid),
        .i_res   (push),
        .o_ready (push_ready),
        .o_res   (o_res)
    );
endmodule
